// ===== rtl/fic_dp_pkg.sv =====
// ----------------------------------------------------------------------------
// FIC depuncturer package
// Shared widths, the erasure reset value and the per-transaction plan type.
// ----------------------------------------------------------------------------
`default_nettype none

package fic_dp_pkg;

	localparam int POS_W     = 12;
	localparam int SOFT_W    = 8;
	localparam int CNT_W     = 2;
	localparam int GROUP_LEN = 32;

	localparam logic [SOFT_W-1:0] ERASURE_RESET = 8'd8;

	typedef logic [SOFT_W-1:0] soft_t;

	typedef struct packed {
		logic [CNT_W-1:0] ers_cnt;
		logic [POS_W-1:0] next_pos;
	} plan_t;

endpackage

`default_nettype wire

// ===== rtl/fic_dp_planner.sv =====
// ----------------------------------------------------------------------------
// FIC depuncturer run planner
// Counts the punctured positions that follow a kept position and gives the
// position that the next received bit fills.
// ----------------------------------------------------------------------------
`default_nettype none

module fic_dp_planner #(
	parameter int REGION_ONE_BITS = 2688,
	parameter int REGION_TWO_END  = 3072,
	parameter int TAIL_BITS       = 24
) (
	input  wire logic [fic_dp_pkg::POS_W-1:0] pos,
	output fic_dp_pkg::plan_t                 plan
);
	import fic_dp_pkg::*;

	localparam int PW        = POS_W + 1;
	localparam int FRAME_LEN = REGION_TWO_END + TAIL_BITS;
	localparam int S2        = (REGION_ONE_BITS < REGION_TWO_END) ? REGION_ONE_BITS
	                                                              : REGION_TWO_END;
	localparam logic [PW-1:0] FRAME_LEN_C = PW'(FRAME_LEN);
	localparam logic [PW-1:0] S2_C        = PW'(S2);
	localparam logic [PW-1:0] R2_C        = PW'(REGION_TWO_END);
	localparam logic [4:0]    GROUP_TAIL  = 5'(GROUP_LEN - 4);

	function automatic logic kept(input logic [PW-1:0] p);
		logic [PW-1:0] off;
		logic          k;
		if (p < S2_C) begin
			k = (p[1:0] != 2'd3);
		end else if (p < R2_C) begin
			off = p - S2_C;
			if (off[4:0] >= GROUP_TAIL) begin
				k = !off[1];
			end else begin
				k = (off[1:0] != 2'd3);
			end
		end else begin
			off = p - R2_C;
			k = !off[1];
		end
		return k;
	endfunction

	logic [PW-1:0] p1;
	logic [PW-1:0] p2;
	logic [PW-1:0] p3;
	logic          ers1;
	logic          ers2;

	always_comb begin
		p1   = {1'b0, pos} + PW'(1);
		p2   = p1 + PW'(1);
		p3   = p2 + PW'(1);
		ers1 = 1'b0;
		ers2 = 1'b0;
		plan.ers_cnt  = '0;
		plan.next_pos = '0;
		if (p1 < FRAME_LEN_C) begin
			if (!kept(p1)) begin
				ers1 = 1'b1;
				if (p2 < FRAME_LEN_C && !kept(p2)) begin
					ers2 = 1'b1;
				end
			end
			if (ers2) begin
				plan.ers_cnt  = CNT_W'(2);
				plan.next_pos = (p3 >= FRAME_LEN_C) ? '0 : p3[POS_W-1:0];
			end else if (ers1) begin
				plan.ers_cnt  = CNT_W'(1);
				plan.next_pos = (p2 >= FRAME_LEN_C) ? '0 : p2[POS_W-1:0];
			end else begin
				plan.next_pos = p1[POS_W-1:0];
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/fic_depuncturer.sv =====
// The input is held in the pending register and each result is then registered
// in the output register. Each input causes 1 to 3 results (about 1.34 on
// average); the output register gives one result per cycle unless stalled.
// A new input is taken while the previous item's last result is loaded.
// Reset clears the frame position to 0 and the erasure value to 8.
// ----------------------------------------------------------------------------
// FIC depuncturer top level
// Rebuilds the mother-code frame from received soft bits, inserting erasures.
// ----------------------------------------------------------------------------
`default_nettype none

module fic_depuncturer #(
	parameter int REGION_ONE_BITS = 2688,
	parameter int REGION_TWO_END  = 3072,
	parameter int TAIL_BITS       = 24
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire fic_dp_pkg::soft_t cfg_wdata,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire fic_dp_pkg::soft_t soft_bit,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output fic_dp_pkg::soft_t      mother_value,
	output logic                   is_erasure,
	output logic                   frame_end,
	output logic                   run_last
);
	import fic_dp_pkg::*;

	localparam int PW = POS_W + 1;
	localparam logic [PW-1:0] FRAME_LAST_C = PW'(REGION_TWO_END + TAIL_BITS - 1);

	soft_t            erasure_q;
	logic [POS_W-1:0] pos_q;
	plan_t            plan;

	logic             pend_valid_q;
	soft_t            pend_val_q;
	logic [PW-1:0]    pend_pos_q;
	logic [CNT_W-1:0] pend_idx_q;
	logic [CNT_W-1:0] pend_cnt_q;

	logic load;
	logic load_last;
	logic item_take;

	fic_dp_planner #(
		.REGION_ONE_BITS(REGION_ONE_BITS),
		.REGION_TWO_END (REGION_TWO_END),
		.TAIL_BITS      (TAIL_BITS)
	) u_planner (
		.pos (pos_q),
		.plan(plan)
	);

	assign load       = pend_valid_q && (!result_valid || !result_stall);
	assign load_last  = load && (pend_idx_q == pend_cnt_q);
	assign item_stall = pend_valid_q && !load_last;
	assign item_take  = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			erasure_q <= ERASURE_RESET;
		end else if (cfg_we) begin
			erasure_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			pend_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				pos_q        <= plan.next_pos;
				pend_valid_q <= 1'b1;
			end else if (load_last) begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			pend_val_q <= soft_bit;
			pend_pos_q <= {1'b0, pos_q};
			pend_idx_q <= '0;
			pend_cnt_q <= plan.ers_cnt;
		end else if (load) begin
			pend_pos_q <= pend_pos_q + PW'(1);
			pend_idx_q <= pend_idx_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mother_value <= (pend_idx_q == '0) ? pend_val_q : erasure_q;
			is_erasure   <= (pend_idx_q != '0);
			frame_end    <= (pend_pos_q == FRAME_LAST_C);
			run_last     <= (pend_idx_q == pend_cnt_q);
		end
	end

	a_run_continues: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !run_last |=> result_valid)
		else $error("run broken before its last result");

	a_frame_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && frame_end |-> run_last)
		else $error("frame end not the last result of its run");

	a_pos_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} <= FRAME_LAST_C)
		else $error("frame position out of range");

	a_take_fills: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |=> pend_valid_q && pend_idx_q == '0)
		else $error("accepted transaction not pending");

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
// ----------------------------------------------------------------------------
// FIC depuncturer testbench
// Drives soft bits through a directed table and then three random phases
// under varying source idle and sink stall rates. Every result is checked
// against the table's expected values or an in-bench frame position tracker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
	import fic_dp_pkg::*;

	localparam int REGION_ONE_BITS = 2688;
	localparam int REGION_TWO_END  = 3072;
	localparam int TAIL_BITS       = 24;
	localparam int FRAME_LEN       = REGION_TWO_END + TAIL_BITS;
	localparam int STALL_LIMIT     = 2000;
	localparam int PHASE_ITEMS     = 137;
	localparam int DIR_ROWS        = 20;

	typedef struct packed {
		soft_t value;
		logic  erasure;
		logic  fend;
		logic  last;
	} mother_t;

	typedef struct packed {
		soft_t      din;
		logic       typed;
		logic [1:0] count;
		mother_t    r0;
		mother_t    r1;
	} dir_row_t;

	// rows after reset: erasure value 8, frame position 0
	dir_row_t dir_table [DIR_ROWS] = '{
		'{8'h00, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b0, 1'b1}, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{8'hFF, 1'b1, 2'd1, '{8'hFF, 1'b0, 1'b0, 1'b1}, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{8'h55, 1'b1, 2'd2, '{8'h55, 1'b0, 1'b0, 1'b0}, '{8'h08, 1'b1, 1'b0, 1'b1}},
		'{8'hAA, 1'b1, 2'd1, '{8'hAA, 1'b0, 1'b0, 1'b1}, '{8'h00, 1'b0, 1'b0, 1'b0}},
		'{8'h01, 1'b0, 2'd0, '0, '0},
		'{8'h80, 1'b0, 2'd0, '0, '0},
		'{8'h7F, 1'b0, 2'd0, '0, '0},
		'{8'hFE, 1'b0, 2'd0, '0, '0},
		'{8'h0F, 1'b0, 2'd0, '0, '0},
		'{8'hF0, 1'b0, 2'd0, '0, '0},
		'{8'h33, 1'b0, 2'd0, '0, '0},
		'{8'hCC, 1'b0, 2'd0, '0, '0},
		'{8'h08, 1'b0, 2'd0, '0, '0},
		'{8'hFF, 1'b0, 2'd0, '0, '0},
		'{8'h00, 1'b0, 2'd0, '0, '0},
		'{8'h5A, 1'b0, 2'd0, '0, '0},
		'{8'hA5, 1'b0, 2'd0, '0, '0},
		'{8'hFF, 1'b0, 2'd0, '0, '0},
		'{8'hFF, 1'b0, 2'd0, '0, '0},
		'{8'h00, 1'b0, 2'd0, '0, '0}
	};

	logic  clk          = 1'b0;
	logic  arst_n       = 1'b0;
	logic  cfg_we       = 1'b0;
	soft_t cfg_wdata    = '0;
	logic  item_valid   = 1'b0;
	soft_t soft_bit     = '0;
	logic  result_stall = 1'b0;
	logic  item_stall;
	logic  result_valid;
	soft_t mother_value;
	logic  is_erasure;
	logic  frame_end;
	logic  run_last;

	logic [POS_W-1:0] frame_pos   = '0;
	soft_t            erasure_cfg = ERASURE_RESET;
	mother_t          mother_q [$];
	mother_t          head;
	int               errors      = 0;
	int               quiet_cycles = 0;
	int               src_idle    = 26;
	int               dst_stall   = 70;

	fic_depuncturer #(
		.REGION_ONE_BITS(REGION_ONE_BITS),
		.REGION_TWO_END (REGION_TWO_END),
		.TAIL_BITS      (TAIL_BITS)
	) dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.item_valid  (item_valid),
		.item_stall  (item_stall),
		.soft_bit    (soft_bit),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.mother_value(mother_value),
		.is_erasure  (is_erasure),
		.frame_end   (frame_end),
		.run_last    (run_last)
	);

	always #5 clk = ~clk;

	function automatic bit kept(input int p);
		int s2;
		int off;
		s2 = (REGION_ONE_BITS < REGION_TWO_END) ? REGION_ONE_BITS : REGION_TWO_END;
		if (p < s2)
			return (p & 3) < 3;
		if (p < REGION_TWO_END) begin
			off = p - s2;
			if ((off % GROUP_LEN) >= GROUP_LEN - 4)
				return (off & 3) < 2;
			return (off & 3) < 3;
		end
		off = p - REGION_TWO_END;
		return (off & 3) < 2;
	endfunction

	task automatic advance_frame(input soft_t v, input bit queue_it);
		int      p;
		int      n;
		int      i;
		mother_t r [3];
		p = frame_pos;
		n = 1;
		r[0] = '{v, 1'b0, (p == FRAME_LEN - 1), 1'b0};
		p++;
		if (p >= FRAME_LEN) begin
			p = 0;
		end else begin
			while (n < 3 && p < FRAME_LEN && !kept(p)) begin
				r[n] = '{erasure_cfg, 1'b1, (p == FRAME_LEN - 1), 1'b0};
				n++;
				p++;
			end
			if (p >= FRAME_LEN)
				p = 0;
		end
		r[n-1].last = 1'b1;
		for (i = 0; i < n; i++) begin
			if (queue_it)
				mother_q.push_back(r[i]);
		end
		frame_pos = p[POS_W-1:0];
	endtask

	task automatic send_soft(input soft_t v);
		while ($urandom_range(99) < src_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		soft_bit   <= v;
		@(posedge clk);
		while (item_stall !== 1'b0)
			@(posedge clk);
	endtask

	task automatic drain;
		item_valid <= 1'b0;
		while (mother_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_erasure(input soft_t v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we      <= 1'b0;
		erasure_cfg = v;
	endtask

	task automatic run_random(input int min_items);
		int    cnt;
		soft_t v;
		cnt = 0;
		while (cnt < min_items) begin
			if ($urandom_range(7) == 0)
				v = $urandom_range(1) ? 8'hFF : 8'h00;
			else
				v = soft_t'($urandom_range(255));
			send_soft(v);
			advance_frame(v, 1'b1);
			cnt++;
		end
		drain();
	endtask

	task automatic flag_mismatch(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	always @(posedge clk) begin
		result_stall <= ($urandom_range(99) < dst_stall);
	end

	always @(posedge clk) begin
		if (arst_n && result_valid === 1'b1 && result_stall === 1'b0) begin
			if (mother_q.size() == 0) begin
				flag_mismatch($sformatf("unexpected transaction value=%h", mother_value));
			end else begin
				head = mother_q.pop_front();
				if (mother_value !== head.value || is_erasure !== head.erasure ||
				    frame_end !== head.fend || run_last !== head.last)
					flag_mismatch($sformatf("got %h/%b/%b/%b want %h/%b/%b/%b",
						mother_value, is_erasure, frame_end, run_last,
						head.value, head.erasure, head.fend, head.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_stall === 1'b0) ||
		    (result_valid === 1'b1 && result_stall === 1'b0))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("status: fail");
		$finish;
	end

	initial begin
		int k;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (k = 0; k < DIR_ROWS; k++) begin
			send_soft(dir_table[k].din);
			advance_frame(dir_table[k].din, !dir_table[k].typed);
			if (dir_table[k].typed) begin
				mother_q.push_back(dir_table[k].r0);
				if (dir_table[k].count == 2)
					mother_q.push_back(dir_table[k].r1);
			end
		end
		drain();

		write_erasure(8'hFF);
		run_random(PHASE_ITEMS);

		src_idle  = 70;
		dst_stall = 26;
		write_erasure(8'h00);
		run_random(PHASE_ITEMS);

		src_idle  = 0;
		dst_stall = 0;
		write_erasure(soft_t'($urandom_range(1, 254)));
		run_random(PHASE_ITEMS);

		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/fic_dp_pkg.sv
rtl/fic_dp_planner.sv
rtl/fic_depuncturer.sv
verif/tb.sv
